>>> rtl/core/mqpt_pkg.sv
// Shared types and constants for the multiplexed quadrature position tracker.
// Used by every module of the block; depends on nothing else.
package mqpt_pkg;

    // Field widths
    localparam int COUNT_W    = 16;
    localparam int SAMPLE_W   = 16;
    localparam int TIMER_W    = 8;
    localparam int SCALE_W    = 16;
    localparam int DIST_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_DB     = 4;

    // Stream packing
    localparam int IN_FIELDS_W  = SAMPLE_W + 6;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 + COUNT_W + DIST_W + 2 + 2 * SAMPLE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Debouncer slots
    localparam int DB_A   = 0;
    localparam int DB_B   = 1;
    localparam int DB_IN  = 2;
    localparam int DB_OUT = 3;

    // Register reset values
    localparam logic [SCALE_W-1:0]       RST_SCALE      = SCALE_W'(16);
    localparam logic                     RST_DIR        = 1'b0;
    localparam logic [TIMER_W-1:0]       RST_ENC_DB     = TIMER_W'(5);
    localparam logic [TIMER_W-1:0]       RST_SW_DB      = TIMER_W'(50);
    localparam logic [TIMER_W-1:0]       RST_MUX_PERIOD = TIMER_W'(20);
    localparam logic                     RST_IN_POL     = 1'b0;
    localparam logic                     RST_OUT_POL    = 1'b0;
    localparam logic signed [DIST_W-1:0] RST_UNCAL_CODE = {1'b1, {(DIST_W-1){1'b0}}};

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE      = 3'd0,
        REG_DIR        = 3'd1,
        REG_ENC_DB     = 3'd2,
        REG_SW_DB      = 3'd3,
        REG_MUX_PERIOD = 3'd4,
        REG_IN_POL     = 3'd5,
        REG_OUT_POL    = 3'd6,
        REG_UNCAL_CODE = 3'd7
    } cfg_reg_t;

    // Configuration register set
    typedef struct packed {
        logic [SCALE_W-1:0]       scale;
        logic                     count_dir;
        logic [TIMER_W-1:0]       enc_db;
        logic [TIMER_W-1:0]       sw_db;
        logic [TIMER_W-1:0]       mux_period;
        logic                     in_pol;
        logic                     out_pol;
        logic signed [DIST_W-1:0] uncal_code;
    } mqpt_cfg_t;

    // One tick item
    typedef struct packed {
        logic                zero_request;
        logic                force_calibrate;
        logic                outward_pin;
        logic                inward_pin;
        logic                encoder_b_pin;
        logic                encoder_a_pin;
        logic [SAMPLE_W-1:0] battery_sample;
    } mqpt_item_t;

    // Tracker state after one tick, handed to the output stage
    typedef struct packed {
        logic                      mux_select;
        logic                      inward_active;
        logic                      outward_active;
        logic signed [COUNT_W-1:0] position_count;
        logic                      is_calibrated;
        logic                      encoder_enabled;
        logic [SAMPLE_W-1:0]       battery_max;
        logic [SAMPLE_W-1:0]       battery_min;
    } mqpt_snap_t;

endpackage

>>> rtl/core/multiplexed_quadrature_position_tracker.sv
// Multiplexed quadrature position tracker, top level. Instantiates mqpt_cfg,
// mqpt_tick and mqpt_out; types come from mqpt_pkg.
//
// Each input transfer is one 1 ms tick. The block accepts one tick per clock
// cycle while the output side is ready and returns exactly one result per tick.
// The tick update (debouncers, mux sequencing, count, calibration, battery
// extremes) is registered into a snapshot register; the distance multiply and
// saturation then fill the result register. Both stages stall together on
// output backpressure. Configuration writes are taken in any cycle and should
// be made while idle; writing the scale register clears the calibrated flag.
module multiplexed_quadrature_position_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    // battery_sample[15:0], encoder_a_pin[16], encoder_b_pin[17], inward_pin[18],
    // outward_pin[19], force_calibrate[20], zero_request[21], zero pad [23:22]
    input  logic [mqpt_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mux_select[0], inward_active[1], outward_active[2], position_count[18:3],
    // distance[34:19], is_calibrated[35], encoder_enabled[36],
    // battery_max[52:37], battery_min[68:53], zero pad [71:69]
    output logic [mqpt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mqpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mqpt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mqpt_pkg::*;

    mqpt_cfg_t  cfg;
    mqpt_item_t item;
    mqpt_snap_t snap;
    logic       scale_wr;
    logic       take;
    logic       load_ok;
    logic       s1_valid_reg;

    assign item     = s_tdata[IN_FIELDS_W-1:0];
    assign s_tready = !s1_valid_reg || load_ok;
    assign take     = s_tvalid && s_tready;

    // Snapshot stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    mqpt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .scale_wr  (scale_wr)
    );

    mqpt_tick u_tick (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .cfg      (cfg),
        .scale_wr (scale_wr),
        .snap     (snap)
    );

    mqpt_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_valid (s1_valid_reg),
        .cfg        (cfg),
        .load_ok    (load_ok),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

>>> rtl/core/mqpt_cfg.sv
// Configuration register file of the position tracker.
// Depends on mqpt_pkg.
module mqpt_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mqpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mqpt_pkg::CFG_DATA_W-1:0] cfg_data,
    output mqpt_pkg::mqpt_cfg_t             cfg,
    output logic                            scale_wr
);
    import mqpt_pkg::*;

    mqpt_cfg_t cfg_reg;
    logic      wr;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign scale_wr  = wr && (cfg_reg_t'(cfg_index) == REG_SCALE);
    assign cfg       = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale      <= RST_SCALE;
            cfg_reg.count_dir  <= RST_DIR;
            cfg_reg.enc_db     <= RST_ENC_DB;
            cfg_reg.sw_db      <= RST_SW_DB;
            cfg_reg.mux_period <= RST_MUX_PERIOD;
            cfg_reg.in_pol     <= RST_IN_POL;
            cfg_reg.out_pol    <= RST_OUT_POL;
            cfg_reg.uncal_code <= RST_UNCAL_CODE;
        end
        else if (wr)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCALE:      cfg_reg.scale      <= cfg_data[SCALE_W-1:0];
                REG_DIR:        cfg_reg.count_dir  <= cfg_data[0];
                REG_ENC_DB:     cfg_reg.enc_db     <= cfg_data[TIMER_W-1:0];
                REG_SW_DB:      cfg_reg.sw_db      <= cfg_data[TIMER_W-1:0];
                REG_MUX_PERIOD: cfg_reg.mux_period <= cfg_data[TIMER_W-1:0];
                REG_IN_POL:     cfg_reg.in_pol     <= cfg_data[0];
                REG_OUT_POL:    cfg_reg.out_pol    <= cfg_data[0];
                REG_UNCAL_CODE: cfg_reg.uncal_code <= $signed(cfg_data[DIST_W-1:0]);
            endcase
        end
    end

endmodule

>>> rtl/core/mqpt_tick.sv
// Per-tick state update: debouncers, mux sequencing, quadrature count,
// calibration and battery trackers, plus the snapshot register. Uses mqpt_pkg.
module mqpt_tick (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  mqpt_pkg::mqpt_item_t item,
    input  mqpt_pkg::mqpt_cfg_t  cfg,
    input  logic                 scale_wr,
    output mqpt_pkg::mqpt_snap_t snap
);
    import mqpt_pkg::*;

    logic [NUM_DB-1:0]               raw_reg, raw_next;
    logic [NUM_DB-1:0]               deb_reg, deb_next;
    logic [NUM_DB-1:0][TIMER_W-1:0]  dt_reg, dt_next;
    logic [TIMER_W-1:0]              mt_reg, mt_next, mt_dec;
    logic                            ms_reg, ms_next;
    logic                            pa_reg, pa_next;
    logic signed [COUNT_W-1:0]       cnt_reg, cnt_next;
    logic                            cal_reg, cal_next;
    logic [SAMPLE_W-1:0]             bhi_reg, bhi_next;
    logic [SAMPLE_W-1:0]             blo_reg, blo_next;
    mqpt_snap_t                      snap_reg, snap_next;

    logic [NUM_DB-1:0]               pin;
    logic [NUM_DB-1:0]               chk;
    logic [NUM_DB-1:0][TIMER_W-1:0]  period;
    logic                            fire;
    logic                            up;
    logic                            in_act, out_act;

    assign pin    = {item.outward_pin, item.inward_pin, item.encoder_b_pin, item.encoder_a_pin};
    assign period = {cfg.sw_db, cfg.sw_db, cfg.enc_db, cfg.enc_db};
    assign mt_dec = (mt_reg != '0) ? mt_reg - TIMER_W'(1) : mt_reg;
    assign fire   = (mt_dec == '0);

    // Which debouncers are checked this tick
    always_comb
    begin
        chk         = '0;
        chk[DB_OUT] = 1'b1;
        chk[DB_IN]  = fire && ms_reg;
        chk[DB_A]   = fire && !ms_reg;
        chk[DB_B]   = fire && !ms_reg;
    end

    // Debouncers, count, mux and calibration
    always_comb
    begin
        raw_next = raw_reg;
        deb_next = deb_reg;
        for (int i = 0; i < NUM_DB; i++)
        begin
            dt_next[i] = (dt_reg[i] != '0) ? dt_reg[i] - TIMER_W'(1) : dt_reg[i];
            if (chk[i])
            begin
                if (pin[i] != raw_reg[i])
                    dt_next[i] = period[i];
                else if (dt_next[i] == '0)
                    deb_next[i] = pin[i];
                raw_next[i] = pin[i];
            end
        end

        mt_next = fire ? cfg.mux_period : mt_dec;
        ms_next = ms_reg;
        if (fire)
            ms_next = (cfg.scale != '0) ? !ms_reg : 1'b1;

        // Quadrature step on a debounced A change
        up       = deb_next[DB_A] ^ deb_next[DB_B] ^ cfg.count_dir;
        pa_next  = pa_reg;
        cnt_next = cnt_reg;
        if (chk[DB_A] && (deb_next[DB_A] != pa_reg))
        begin
            pa_next  = deb_next[DB_A];
            cnt_next = up ? cnt_reg + COUNT_W'(1) : cnt_reg - COUNT_W'(1);
        end

        in_act   = deb_next[DB_IN] ^ cfg.in_pol;
        out_act  = deb_next[DB_OUT] ^ cfg.out_pol;
        cal_next = cal_reg;
        if (in_act || item.force_calibrate)
        begin
            cnt_next = '0;
            cal_next = 1'b1;
        end
        if (item.zero_request)
            cnt_next = '0;
    end

    // Battery extremes
    always_comb
    begin
        bhi_next = (item.battery_sample > bhi_reg) ? item.battery_sample : bhi_reg;
        blo_next = (item.battery_sample < blo_reg) ? item.battery_sample : blo_reg;
    end

    // Snapshot for the output stage
    always_comb
    begin
        snap_next.mux_select      = ms_next;
        snap_next.inward_active   = in_act;
        snap_next.outward_active  = out_act;
        snap_next.position_count  = cnt_next;
        snap_next.is_calibrated   = cal_next;
        snap_next.encoder_enabled = (cfg.scale != '0);
        snap_next.battery_max     = bhi_next;
        snap_next.battery_min     = blo_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= '0;
            deb_reg <= '0;
            dt_reg  <= {RST_SW_DB, RST_SW_DB, RST_ENC_DB, RST_ENC_DB};
            mt_reg  <= RST_MUX_PERIOD;
            ms_reg  <= 1'b1;
            pa_reg  <= 1'b0;
            cnt_reg <= '0;
            cal_reg <= 1'b0;
            bhi_reg <= '0;
            blo_reg <= '1;
        end
        else
        begin
            if (take)
            begin
                raw_reg <= raw_next;
                deb_reg <= deb_next;
                dt_reg  <= dt_next;
                mt_reg  <= mt_next;
                ms_reg  <= ms_next;
                pa_reg  <= pa_next;
                cnt_reg <= cnt_next;
                bhi_reg <= bhi_next;
                blo_reg <= blo_next;
            end
            if (scale_wr)
                cal_reg <= 1'b0;
            else if (take)
                cal_reg <= cal_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
            snap_reg <= snap_next;
    end

    assign snap = snap_reg;

endmodule

>>> rtl/core/mqpt_out.sv
// Output stage: scales the count to a saturated distance, or gives the uncalibrated
// code, and holds the result transfer until taken. Uses mqpt_pkg.
module mqpt_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mqpt_pkg::mqpt_snap_t              snap,
    input  logic                              snap_valid,
    input  mqpt_pkg::mqpt_cfg_t               cfg,
    output logic                              load_ok,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mqpt_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import mqpt_pkg::*;

    localparam int PROD_W = COUNT_W + SCALE_W + 1;
    localparam int PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;
    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    logic                        m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;
    logic signed [PROD_W-1:0]    prod;
    logic [PROD_W-DIST_W:0]      prod_hi;
    logic signed [DIST_W-1:0]    dist_val;

    // Count times scale, saturated
    always_comb
    begin
        prod    = snap.position_count * $signed({1'b0, cfg.scale});
        prod_hi = prod[PROD_W-1:DIST_W-1];
        if (!snap.is_calibrated || (cfg.scale == '0))
            dist_val = cfg.uncal_code;
        else if ((prod_hi == '0) || (prod_hi == '1))
            dist_val = prod[DIST_W-1:0];
        else if (prod[PROD_W-1])
            dist_val = DIST_MIN;
        else
            dist_val = DIST_MAX;
    end

    assign m_tdata_next = {PAD_W'(0), snap.battery_min, snap.battery_max,
                           snap.encoder_enabled, snap.is_calibrated, dist_val,
                           snap.position_count, snap.outward_active,
                           snap.inward_active, snap.mux_select};

    assign load_ok = !m_tvalid_reg || m_tready;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (load_ok)
            m_tvalid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && snap_valid)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/core/mqpt_checker.sv
// Port-level checks for the position tracker, bound to the top level.
// Depends on mqpt_pkg and multiplexed_quadrature_position_tracker.
module mqpt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic [mqpt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready
);
    import mqpt_pkg::*;

    logic                inward_active;
    logic                is_calibrated;
    logic                encoder_enabled;
    logic [COUNT_W-1:0]  position_count;
    logic [DIST_W-1:0]   distance;
    logic [SAMPLE_W-1:0] battery_max;
    logic [SAMPLE_W-1:0] battery_min;

    assign inward_active   = m_tdata[1];
    assign position_count  = m_tdata[18:3];
    assign distance        = m_tdata[34:19];
    assign is_calibrated   = m_tdata[35];
    assign encoder_enabled = m_tdata[36];
    assign battery_max     = m_tdata[52:37];
    assign battery_min     = m_tdata[68:53];

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every result has seen at least one sample
    a_batt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> battery_max >= battery_min)
        else $error("battery max below min");

    // Active inward endstop zeroes and calibrates
    a_endstop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && inward_active |-> position_count == '0 && is_calibrated)
        else $error("endstop did not zero the count");

    // Zero count gives zero distance when valid, calibrated and enabled
    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && is_calibrated && encoder_enabled && position_count == '0
        |-> distance == '0)
        else $error("nonzero distance at zero count");

endmodule

bind multiplexed_quadrature_position_tracker mqpt_checker u_mqpt_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for multiplexed_quadrature_position_tracker.
// Tick items stream in, a tick-by-tick tracker model predicts each result, and a
// monitor compares every field. Depends on rtl/core/mqpt_pkg.sv and the top level.
`timescale 1ns / 1ps

module tb_top;
    import mqpt_pkg::*;

    // Result layout on m_tdata, lowest field last
    typedef struct packed {
        logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
        logic [SAMPLE_W-1:0]                 battery_min;
        logic [SAMPLE_W-1:0]                 battery_max;
        logic                                encoder_enabled;
        logic                                is_calibrated;
        logic [DIST_W-1:0]                   distance;
        logic [COUNT_W-1:0]                  position_count;
        logic                                outward_active;
        logic                                inward_active;
        logic                                mux_select;
    } tick_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    multiplexed_quadrature_position_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Queues between stimulus, driver and monitor
    mqpt_item_t   pending_ticks[$];
    tick_result_t expected_snapshots[$];
    int           error_count = 0;

    // Idling controls, changed only while the block is idle
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    // Long receiver hold-off
    bit hold_armed = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;

    // Tracker model: configuration copy and state
    mqpt_cfg_t          tracker_cfg;
    logic [NUM_DB-1:0]  pin_last;
    logic [NUM_DB-1:0]  pin_stable;
    logic [TIMER_W-1:0] settle_timer [NUM_DB];
    logic [TIMER_W-1:0] mux_countdown;
    logic               sense_endstop;
    logic               last_a;
    logic [COUNT_W-1:0] position;
    logic               calibrated;
    logic [SAMPLE_W-1:0] battery_peak;
    logic [SAMPLE_W-1:0] battery_floor;

    // Stimulus generator state
    logic [1:0] quad_phase = 2'd0;
    logic       walk_up = 1'b1;
    logic       gen_inward = 1'b0;
    logic       gen_outward = 1'b0;
    int         run_left = 0;
    int         max_run = 8;

    // Clock
    initial begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("multiplexed_quadrature_position_tracker test failed");
        $finish;
    end

    task automatic report_error(string msg);
        if (error_count < 40)
            $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Debounce check of one pin slot
    function automatic void sample_pin(int slot, logic level);
        logic [TIMER_W-1:0] period;
        period = (slot == DB_A || slot == DB_B) ? tracker_cfg.enc_db : tracker_cfg.sw_db;
        if (level != pin_last[slot])
            settle_timer[slot] = period;
        else if (settle_timer[slot] == '0)
            pin_stable[slot] = level;
        pin_last[slot] = level;
    endfunction

    // Advance the tracker model by one tick and return the expected result
    function automatic tick_result_t predict_tick(mqpt_item_t it);
        tick_result_t r;
        logic         a;
        logic         b;
        logic         up;
        longint       prod;
        r = '0;
        if (it.battery_sample > battery_peak)
            battery_peak = it.battery_sample;
        if (it.battery_sample < battery_floor)
            battery_floor = it.battery_sample;

        for (int i = 0; i < NUM_DB; i++)
            if (settle_timer[i] != '0)
                settle_timer[i] = settle_timer[i] - 1'b1;
        if (mux_countdown != '0)
            mux_countdown = mux_countdown - 1'b1;

        sample_pin(DB_OUT, it.outward_pin);

        // Mux sampling point
        if (mux_countdown == '0) begin
            mux_countdown = tracker_cfg.mux_period;
            if (sense_endstop) begin
                sample_pin(DB_IN, it.inward_pin);
            end
            else begin
                sample_pin(DB_A, it.encoder_a_pin);
                sample_pin(DB_B, it.encoder_b_pin);
                a = pin_stable[DB_A];
                b = pin_stable[DB_B];
                if (a != last_a) begin
                    last_a = a;
                    up = a ? ~b : b;
                    if (tracker_cfg.count_dir)
                        up = ~up;
                    position = up ? position + 1'b1 : position - 1'b1;
                end
            end
            sense_endstop = (tracker_cfg.scale != '0) ? ~sense_endstop : 1'b1;
        end

        r.inward_active  = pin_stable[DB_IN] ^ tracker_cfg.in_pol;
        r.outward_active = pin_stable[DB_OUT] ^ tracker_cfg.out_pol;

        // Zeroing after the mux step
        if (r.inward_active || it.force_calibrate) begin
            position   = '0;
            calibrated = 1'b1;
        end
        if (it.zero_request)
            position = '0;

        if (!calibrated || tracker_cfg.scale == '0) begin
            r.distance = tracker_cfg.uncal_code;
        end
        else begin
            prod = longint'($signed(position)) * longint'(tracker_cfg.scale);
            if (prod > 32767)
                prod = 32767;
            else if (prod < -32768)
                prod = -32768;
            r.distance = prod[15:0];
        end

        r.mux_select      = sense_endstop;
        r.position_count  = position;
        r.is_calibrated   = calibrated;
        r.encoder_enabled = (tracker_cfg.scale != '0);
        r.battery_max     = battery_peak;
        r.battery_min     = battery_floor;
        return r;
    endfunction

    // Input driver: holds an offered item until it transfers
    always @(posedge clk) begin
        bit took;
        if (rst_n) begin
            took = s_tvalid && s_tready;
            if (took)
                void'(pending_ticks.pop_front());
            if (!s_tvalid || took) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_TDATA_W'(pending_ticks[0]);
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off counter
    always @(posedge clk) begin
        if (hold_armed && !hold_taken) begin
            hold_left  <= 400;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready with random stalls
    always @(posedge clk) begin
        if (rst_n)
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    // Monitor: check the result transfer, then predict the input transfer
    always @(posedge clk) begin
        tick_result_t got;
        tick_result_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = tick_result_t'(m_tdata);
                if (expected_snapshots.size() == 0) begin
                    report_error("result transfer with nothing expected");
                end
                else begin
                    want = expected_snapshots.pop_front();
                    compare_field("mux_select", 16'(got.mux_select), 16'(want.mux_select));
                    compare_field("inward_active", 16'(got.inward_active),
                                  16'(want.inward_active));
                    compare_field("outward_active", 16'(got.outward_active),
                                  16'(want.outward_active));
                    compare_field("position_count", got.position_count, want.position_count);
                    compare_field("distance", got.distance, want.distance);
                    compare_field("is_calibrated", 16'(got.is_calibrated),
                                  16'(want.is_calibrated));
                    compare_field("encoder_enabled", 16'(got.encoder_enabled),
                                  16'(want.encoder_enabled));
                    compare_field("battery_max", got.battery_max, want.battery_max);
                    compare_field("battery_min", got.battery_min, want.battery_min);
                end
            end
            if (s_tvalid && s_tready)
                expected_snapshots.push_back(predict_tick(mqpt_item_t'(s_tdata[IN_FIELDS_W-1:0])));
        end
    end

    // One register write; cfg_valid stays high for back-to-back writes
    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SCALE: begin
                tracker_cfg.scale = value;
                calibrated = 1'b0;
            end
            REG_DIR:        tracker_cfg.count_dir  = value[0];
            REG_ENC_DB:     tracker_cfg.enc_db     = value[TIMER_W-1:0];
            REG_SW_DB:      tracker_cfg.sw_db      = value[TIMER_W-1:0];
            REG_MUX_PERIOD: tracker_cfg.mux_period = value[TIMER_W-1:0];
            REG_IN_POL:     tracker_cfg.in_pol     = value[0];
            REG_OUT_POL:    tracker_cfg.out_pol    = value[0];
            REG_UNCAL_CODE: tracker_cfg.uncal_code = value;
            default: ;
        endcase
    endtask

    task automatic queue_item(logic [15:0] batt, logic a, logic b, logic inw, logic outw,
                              logic force_cal, logic zero_req);
        mqpt_item_t it;
        it.battery_sample  = batt;
        it.encoder_a_pin   = a;
        it.encoder_b_pin   = b;
        it.inward_pin      = inw;
        it.outward_pin     = outw;
        it.force_calibrate = force_cal;
        it.zero_request    = zero_req;
        pending_ticks.push_back(it);
    endtask

    // Random ticks: pins held for runs, encoder walking in Gray order, with glitches
    task automatic queue_ticks(int n);
        mqpt_item_t it;
        for (int k = 0; k < n; k++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(max_run, 1);
                if ($urandom_range(7) == 0)
                    walk_up = ~walk_up;
                if ($urandom_range(11) == 0)
                    quad_phase = 2'($urandom_range(3));
                else
                    quad_phase = walk_up ? quad_phase + 2'd1 : quad_phase - 2'd1;
                if ($urandom_range(5) == 0)
                    gen_inward = ~gen_inward;
                if ($urandom_range(4) == 0)
                    gen_outward = ~gen_outward;
            end
            run_left--;
            it.encoder_a_pin = quad_phase[1];
            it.encoder_b_pin = quad_phase[1] ^ quad_phase[0];
            it.inward_pin    = gen_inward;
            it.outward_pin   = gen_outward;
            // single-tick glitch on one pin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: it.encoder_a_pin = ~it.encoder_a_pin;
                    1: it.encoder_b_pin = ~it.encoder_b_pin;
                    2: it.inward_pin    = ~it.inward_pin;
                    default: it.outward_pin = ~it.outward_pin;
                endcase
            end
            case ($urandom_range(9))
                0: it.battery_sample = '0;
                1: it.battery_sample = '1;
                default: it.battery_sample = SAMPLE_W'($urandom);
            endcase
            it.force_calibrate = ($urandom_range(49) == 0);
            it.zero_request    = ($urandom_range(39) == 0);
            pending_ticks.push_back(it);
        end
    endtask

    // Wait until every item has transferred and every result has arrived
    task automatic wait_idle();
        do @(posedge clk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_snapshots.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(logic [15:0] scale, logic dir, logic [7:0] enc, logic [7:0] sw,
                             logic [7:0] mux, logic ipol, logic opol, logic [15:0] uncal,
                             int tx, int rx, int n, bit pressure);
        wait_idle();
        write_register(REG_SCALE, scale);
        write_register(REG_DIR, 16'(dir));
        write_register(REG_ENC_DB, 16'(enc));
        write_register(REG_SW_DB, 16'(sw));
        write_register(REG_MUX_PERIOD, 16'(mux));
        write_register(REG_IN_POL, 16'(ipol));
        write_register(REG_OUT_POL, 16'(opol));
        write_register(REG_UNCAL_CODE, uncal);
        cfg_valid <= 1'b0;
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        // runs long enough for the encoder to settle across mux sampling points
        max_run = int'(mux) * 4 + int'(enc) + 6;
        if (max_run > 80)
            max_run = 80;
        if (pressure)
            hold_armed <= 1'b1;
        queue_ticks(n);
    endtask

    // Sequencer
    initial begin
        tracker_cfg.scale      = RST_SCALE;
        tracker_cfg.count_dir  = RST_DIR;
        tracker_cfg.enc_db     = RST_ENC_DB;
        tracker_cfg.sw_db      = RST_SW_DB;
        tracker_cfg.mux_period = RST_MUX_PERIOD;
        tracker_cfg.in_pol     = RST_IN_POL;
        tracker_cfg.out_pol    = RST_OUT_POL;
        tracker_cfg.uncal_code = RST_UNCAL_CODE;
        pin_last        = '0;
        pin_stable      = '0;
        settle_timer[DB_A]   = RST_ENC_DB;
        settle_timer[DB_B]   = RST_ENC_DB;
        settle_timer[DB_IN]  = RST_SW_DB;
        settle_timer[DB_OUT] = RST_SW_DB;
        mux_countdown   = RST_MUX_PERIOD;
        sense_endstop   = 1'b1;
        last_a          = 1'b0;
        position        = '0;
        calibrated      = 1'b0;
        battery_peak    = '0;
        battery_floor   = '1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, force and zero requests, then a steady run
        // through the first mux sampling point at the reset settings
        queue_item(16'hFFFF, 1, 1, 1, 1, 0, 0);
        queue_item(16'h0000, 0, 0, 0, 0, 0, 0);
        queue_item(16'h8000, 1, 0, 0, 1, 0, 0);
        queue_item(16'h1234, 0, 1, 1, 0, 1, 0);
        queue_item(16'h4321, 0, 0, 0, 0, 0, 1);
        queue_item(16'h00FF, 1, 1, 0, 0, 1, 1);
        queue_item(16'hFF00, 0, 0, 1, 1, 0, 0);
        for (int k = 0; k < 16; k++)
            queue_item(16'(16'h5A5A + k), 1, 1, 1, 1, 0, 0);
        max_run = 90;
        queue_ticks(150);

        // Zero debounce, shortest mux period
        run_phase(16, 0, 0, 0, 1, 0, 0, 16'h8000, 80, 0, 250, 0);
        // Upper extremes everywhere
        run_phase(16'hFFFF, 1, 8'hFF, 8'hFF, 8'hFF, 1, 1, 16'h7FFF, 0, 80, 200, 0);
        // Encoder disabled, mux timer expiring every tick
        run_phase(0, 0, 2, 3, 0, 0, 0, 16'h0000, 11, 11, 250, 0);
        // Large scale for saturation, with the long receiver hold-off
        run_phase(1000, 1, 1, 2, 2, 1, 0, 16'h1234, 11, 11, 300, 1);
        run_phase(1, 0, 3, 1, 3, 0, 1, 16'($urandom), 0, 0, 250, 0);
        // Random settings
        run_phase(16'($urandom_range(2000, 1)), 1'($urandom), 8'($urandom_range(4)),
                  8'($urandom_range(6)), 8'($urandom_range(4)), 1'($urandom),
                  1'($urandom), 16'($urandom), 80, 0, 200, 0);
        run_phase(16'($urandom_range(2000, 1)), 1'($urandom), 8'($urandom_range(4)),
                  8'($urandom_range(6)), 8'($urandom_range(4)), 1'($urandom),
                  1'($urandom), 16'($urandom), 0, 80, 200, 0);
        run_phase(16'($urandom), 1'($urandom), 8'($urandom_range(3)),
                  8'($urandom_range(3)), 8'($urandom_range(3)), 1'($urandom),
                  1'($urandom), 16'($urandom), 0, 0, 150, 0);

        wait_idle();
        repeat (10) @(posedge clk);
        if (expected_snapshots.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_snapshots.size()));

        if (error_count == 0)
            $display("multiplexed_quadrature_position_tracker test passed");
        else
            $display("multiplexed_quadrature_position_tracker test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/mqpt_pkg.sv
rtl/core/mqpt_cfg.sv
rtl/core/mqpt_tick.sv
rtl/core/mqpt_out.sv
rtl/core/multiplexed_quadrature_position_tracker.sv
rtl/core/mqpt_checker.sv
verif/tb_top.sv
